[design/stks_pkg.sv]
// Shared types and constants for the streaming top-k selector.
package stks_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W = 16;
   localparam int KEPT_W = 4;
   localparam int RNUM_W = 3;

   localparam int MAX_RANKS_DEF = 8;
   localparam int MAX_SET_ITEMS_DEF = 65536;
   localparam logic [KEPT_W-1:0] KEPT_COUNT_RESET = KEPT_W'(8);

   typedef struct packed {
      logic                      filled;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } slot_type;

   localparam slot_type SLOT_EMPTY = '{filled: 1'b0, value: '0, position: '0};

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT_UP,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } chain_ctrl_type;

   typedef enum logic {
      ST_COLLECT,
      ST_REPORT
   } state_type;

endpackage

[design/stks_if.sv]
// Request and response channel interfaces of the top-k selector.
interface stks_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [stks_pkg::VALUE_W-1:0] sample_value;
   logic                                set_last;

   modport source (output valid, output sample_value, output set_last, input ready);
   modport sink (input valid, input sample_value, input set_last, output ready);
endinterface

interface stks_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [stks_pkg::RNUM_W-1:0]         rank_number;
   logic [stks_pkg::POS_W-1:0]          rank_position;
   logic signed [stks_pkg::VALUE_W-1:0] rank_value;
   logic                                rank_valid;
   logic                                rank_last;

   modport source (output valid, output rank_number, output rank_position,
                   output rank_value, output rank_valid, output rank_last, input ready);
   modport sink (input valid, input rank_number, input rank_position,
                 input rank_value, input rank_valid, input rank_last, output ready);
endinterface

[design/streaming_top_k_select.sv]
// Streaming top-k selector: top level with control and report sequencing.
//
// Usage: values arrive on req_chan, one request per element, numbered from 0
// within a set; set_last closes the set. Every element enters the rank chain
// in the cycle it is accepted, so a set streams in at one element per cycle.
// In the cycle after the set closes, rsp_chan presents rank 0 from the head
// cell; each accepted response shifts the chain up by one cell, so ranks
// leave at one per cycle while the receiver takes them. kept_count
// (csr_wr_en/csr_wr_data, 0 read as 1, clamped to MAX_RANKS) sets how many
// ranks are reported; after the final one the whole chain is cleared in the
// same cycle and req_chan.ready rises again in the next one.
// While responses are pending req_chan.ready stays low; a stalled receiver
// holds the current rank steady and stalls intake with it.
// Reset empties every cell, zeroes the position counter and sets kept_count
// to 8; the block is ready in the first cycle after reset.
module streaming_top_k_select #(
   parameter int MAX_RANKS = stks_pkg::MAX_RANKS_DEF,
   parameter int MAX_SET_ITEMS = stks_pkg::MAX_SET_ITEMS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   stks_req_if.sink                    req_chan,
   stks_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [stks_pkg::KEPT_W-1:0] csr_wr_data
);
   import stks_pkg::*;

   localparam int IDX_W = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
   localparam int POS_LIMIT_INT = (MAX_SET_ITEMS - 1 > 65535) ? 65535 : MAX_SET_ITEMS - 1;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_INT);

   state_type          state_ff, state_in;
   logic [KEPT_W-1:0]  kept_count_ff;
   logic [POS_W-1:0]   position_ff, position_in;
   logic [IDX_W-1:0]   rank_ff, rank_in;
   logic [IDX_W-1:0]   last_rank_ff, last_rank_in;
   logic [IDX_W-1:0]   kept_last;
   logic [31:0]        kept_ext;
   logic               req_fire, rsp_fire;
   chain_ctrl_type     chain_ctrl;
   slot_type           head_slot;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // clamp kept_count to 1..MAX_RANKS, held as index of the final rank
   assign kept_ext = 32'(kept_count_ff);
   always_comb begin
      if (kept_ext == 32'd0) begin
         kept_last = '0;
      end else if (kept_ext > 32'(MAX_RANKS)) begin
         kept_last = IDX_W'(MAX_RANKS - 1);
      end else begin
         kept_last = IDX_W'(kept_ext - 32'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_count_ff <= KEPT_COUNT_RESET;
      end else if (csr_wr_en) begin
         kept_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         position_ff <= '0;
         rank_ff <= '0;
         last_rank_ff <= '0;
      end else begin
         state_ff <= state_in;
         position_ff <= position_in;
         rank_ff <= rank_in;
         last_rank_ff <= last_rank_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      position_in = position_ff;
      rank_in = rank_ff;
      last_rank_in = last_rank_ff;
      chain_ctrl.op = CELL_HOLD;
      chain_ctrl.value = req_chan.sample_value;
      chain_ctrl.position = position_ff;
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            req_chan.ready = 1'b1;
            if (req_fire) begin
               chain_ctrl.op = CELL_INSERT;
               if (req_chan.set_last) begin
                  position_in = '0;
                  rank_in = '0;
                  last_rank_in = kept_last;
                  state_in = ST_REPORT;
               end else if (position_ff < POS_LIMIT) begin
                  position_in = position_ff + POS_W'(1);
               end
            end
         end
         ST_REPORT: begin
            rsp_chan.valid = 1'b1;
            if (rsp_fire) begin
               if (rank_ff == last_rank_ff) begin
                  chain_ctrl.op = CELL_CLEAR;
                  rank_in = '0;
                  state_in = ST_COLLECT;
               end else begin
                  chain_ctrl.op = CELL_SHIFT_UP;
                  rank_in = rank_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   stks_chain #(
      .MAX_RANKS (MAX_RANKS)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (chain_ctrl),
      .head_slot (head_slot)
   );

   assign rsp_chan.rank_number = RNUM_W'(rank_ff);
   assign rsp_chan.rank_position = head_slot.filled ? head_slot.position : '0;
   assign rsp_chan.rank_value = head_slot.filled ? head_slot.value : '0;
   assign rsp_chan.rank_valid = head_slot.filled;
   assign rsp_chan.rank_last = (rank_ff == last_rank_ff);

endmodule

[design/stks_cell.sv]
// One rank slot of the insertion chain.
module stks_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  stks_pkg::chain_ctrl_type ctrl,
   input  stks_pkg::slot_type       prev_slot,
   input  logic                     prev_ins,
   input  stks_pkg::slot_type       prev_run_first,
   input  stks_pkg::slot_type       next_slot,
   output stks_pkg::slot_type       slot,
   output logic                     ins,
   output stks_pkg::slot_type       run_first
);
   import stks_pkg::*;

   logic                      filled_ff, filled_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]          position_ff, position_in;
   logic                      run_start;

   // strict compare keeps the earlier entry ahead on ties
   assign ins = !filled_ff || (ctrl.value > value_ff);

   // this cell opens a run of equal values; pass on the entry heading the run
   assign run_start = !prev_slot.filled || !filled_ff || (prev_slot.value != value_ff);
   assign run_first = run_start ? slot : prev_run_first;

   always_comb begin
      filled_in = filled_ff;
      value_in = value_ff;
      position_in = position_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (prev_ins) begin
               // displaced run head lands past its equals; equal entries stay put
               if (prev_slot.filled && run_start) begin
                  filled_in = prev_run_first.filled;
                  value_in = prev_run_first.value;
                  position_in = prev_run_first.position;
               end
            end else if (ins) begin
               filled_in = 1'b1;
               value_in = ctrl.value;
               position_in = ctrl.position;
            end
         end
         CELL_SHIFT_UP: begin
            filled_in = next_slot.filled;
            value_in = next_slot.value;
            position_in = next_slot.position;
         end
         CELL_CLEAR: begin
            filled_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= 1'b0;
      end else begin
         filled_ff <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      position_ff <= position_in;
   end

   assign slot = '{filled: filled_ff, value: value_ff, position: position_ff};

endmodule

[design/stks_chain.sv]
// Row of rank cells; rank 0 sits at the head.
module stks_chain #(
   parameter int MAX_RANKS = stks_pkg::MAX_RANKS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  stks_pkg::chain_ctrl_type ctrl,
   output stks_pkg::slot_type       head_slot
);
   import stks_pkg::*;

   slot_type slots [MAX_RANKS];
   slot_type firsts [MAX_RANKS];
   logic     ins [MAX_RANKS];

   for (genvar j = 0; j < MAX_RANKS; j++) begin : g_cell
      slot_type prev_slot, next_slot, prev_first;
      logic     prev_ins;

      if (j == 0) begin : g_first
         assign prev_slot = SLOT_EMPTY;
         assign prev_ins = 1'b0;
         assign prev_first = SLOT_EMPTY;
      end else begin : g_mid
         assign prev_slot = slots[j-1];
         assign prev_ins = ins[j-1];
         assign prev_first = firsts[j-1];
      end

      if (j == MAX_RANKS - 1) begin : g_tail
         assign next_slot = SLOT_EMPTY;
      end else begin : g_body
         assign next_slot = slots[j+1];
      end

      stks_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .prev_slot      (prev_slot),
         .prev_ins       (prev_ins),
         .prev_run_first (prev_first),
         .next_slot      (next_slot),
         .slot           (slots[j]),
         .ins            (ins[j]),
         .run_first      (firsts[j])
      );
   end

   assign head_slot = slots[0];

endmodule

[design/stks_chk.sv]
// Port-level checks for the top-k selector, bound to the top level.
module stks_chk (
   input logic        clock,
   input logic        reset,
   stks_req_if.sink   req_chan,
   stks_rsp_if.source rsp_chan
);
   import stks_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid)
      else $error("response dropped while stalled");

   a_no_intake_in_report: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request taken while ranks pending");

   a_report_starts: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && req_chan.set_last
      |=> rsp_chan.valid && rsp_chan.rank_number == '0)
      else $error("report did not start at rank 0");

   a_rank_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.rank_last
      |=> rsp_chan.valid
          && rsp_chan.rank_number == RNUM_W'($past(rsp_chan.rank_number) + 1'b1))
      else $error("rank sequence broken");

endmodule

bind streaming_top_k_select stks_chk u_stks_chk (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
